// File: design/mcm_pkg.sv
// ----------------------------------------------------------------------------
// mcm_pkg
// Shared types and constants of the 4x4 column-major matrix multiply unit.
// ----------------------------------------------------------------------------
`default_nettype none

package mcm_pkg;

  localparam int N            = 4;
  localparam int ELEM_W       = 32;
  localparam int COL_W        = 2;
  localparam int PROD_W       = 2 * ELEM_W;
  localparam int FRAC_BITS_DEF = 16;

  localparam int DATA_BITS = COL_W + N * ELEM_W;
  localparam int DATA_W    = ((DATA_BITS + 7) / 8) * 8;

  localparam logic [ELEM_W-1:0] SAT_MAX = {1'b0, {(ELEM_W-1){1'b1}}};
  localparam logic [ELEM_W-1:0] SAT_MIN = {1'b1, {(ELEM_W-1){1'b0}}};

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_MUL  = 1'b1
  } op_t;

  typedef logic [COL_W-1:0]                       col_t;
  typedef logic [N-1:0][ELEM_W-1:0]               col_vec_t;
  typedef logic [N-1:0][N-1:0][ELEM_W-1:0]        mat_t;
  typedef logic [N-1:0][N-1:0][PROD_W-1:0]        prod_mat_t;

  typedef struct packed {
    logic vld;
    col_t col;
  } stage_tag_t;

endpackage

`default_nettype wire

// File: design/mat4_column_major_multiply_unit.sv
// ----------------------------------------------------------------------------
// mat4_column_major_multiply_unit
// C = A * B on 4x4 column-major Q16.16 matrices, one column per transfer.
//
//   channel  dir  handshake            payload
//   in_      in   in_tvalid/in_tready  tuser: operation; tdata: column, elem0..3
//   out_     out  out_tvalid/out_tready tdata: out_column, prod0..3
//
// One item is taken each cycle while in_tready is high. A multiply result
// passes the input register, multipliers, pair adders and the final add with
// saturation in the output register. A load writes its column of A at its
// transfer and yields no result; a multiply taken in the next cycle sees it.
// Reset clears the valid bits only; the A store is undefined until loaded.
// A stalled output holds each full stage up to the first empty one; nothing is dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module mat4_column_major_multiply_unit #(
  parameter int FRAC_BITS = mcm_pkg::FRAC_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_tvalid,
  output logic                              in_tready,
  // column[1:0], elem0[33:2], elem1[65:34], elem2[97:66], elem3[129:98], zero
  input  wire logic [mcm_pkg::DATA_W-1:0]   in_tdata,
  // operation[0]
  input  wire logic                         in_tuser,
  output logic                              out_tvalid,
  input  wire logic                         out_tready,
  // out_column[1:0], prod0[33:2], prod1[65:34], prod2[97:66], prod3[129:98], zero
  output logic [mcm_pkg::DATA_W-1:0]        out_tdata
);
  import mcm_pkg::*;

  op_t        in_op;
  col_t       in_col;
  col_vec_t   in_elem;
  logic       in_fire;
  logic       load_en;

  stage_tag_t s1_tag_r;
  col_vec_t   s1_b_r;
  logic       s2_rdy;

  mat_t       mat;
  stage_tag_t mul_tag;
  prod_mat_t  mul_prod;
  logic       red_rdy;
  stage_tag_t res_tag;
  col_vec_t   res_sum;

  assign in_op   = op_t'(in_tuser);
  assign in_col  = in_tdata[COL_W-1:0];
  assign in_elem = in_tdata[DATA_BITS-1:COL_W];

  assign in_tready = !s1_tag_r.vld || s2_rdy;
  assign in_fire   = in_tvalid && in_tready;
  assign load_en   = in_fire && (in_op == OP_LOAD);

  always_ff @(posedge clk) begin
    if (in_tready) begin
      s1_tag_r.col <= in_col;
      s1_b_r       <= in_elem;
    end
    if (!rst_n) begin
      s1_tag_r.vld <= 1'b0;
    end else if (in_tready) begin
      s1_tag_r.vld <= in_tvalid && (in_op == OP_MUL);
    end
  end

  mcm_col_store u_store (
    .clk     (clk),
    .wr_en   (load_en),
    .wr_col  (in_col),
    .wr_data (in_elem),
    .mat     (mat)
  );

  mcm_mul u_mul (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tag   (s1_tag_r),
    .in_b     (s1_b_r),
    .mat      (mat),
    .in_rdy   (s2_rdy),
    .out_tag  (mul_tag),
    .out_prod (mul_prod),
    .out_rdy  (red_rdy)
  );

  mcm_reduce #(
    .FRAC_BITS (FRAC_BITS)
  ) u_reduce (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_tag  (mul_tag),
    .in_prod (mul_prod),
    .in_rdy  (red_rdy),
    .out_tag (res_tag),
    .out_sum (res_sum),
    .out_rdy (out_tready)
  );

  assign out_tvalid = res_tag.vld;
  assign out_tdata  = {{(DATA_W-DATA_BITS){1'b0}}, res_sum, res_tag.col};

`ifndef ASSERT_OFF
  a_mul_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_op == OP_MUL) |=> s1_tag_r.vld)
    else $error("accepted multiply did not enter the input stage");

  a_load_written: assert property (@(posedge clk) disable iff (!rst_n)
    load_en |=> (mat[$past(in_col)] == $past(in_elem)))
    else $error("loaded column not held in the A store");

  a_load_no_overtake: assert property (@(posedge clk) disable iff (!rst_n)
    (load_en && s1_tag_r.vld) |-> s2_rdy)
    else $error("load changed A under a held multiply");
`endif

endmodule

`default_nettype wire

// File: design/mcm_col_store.sv
// ----------------------------------------------------------------------------
// mcm_col_store
// Left matrix register file, written one column at a time, read in full.
// ----------------------------------------------------------------------------
`default_nettype none

module mcm_col_store (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire mcm_pkg::col_t    wr_col,
  input  wire mcm_pkg::col_vec_t wr_data,
  output mcm_pkg::mat_t         mat
);
  import mcm_pkg::*;

  mat_t mat_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mat_r[wr_col] <= wr_data;
    end
  end

  assign mat = mat_r;

endmodule

`default_nettype wire

// File: design/mcm_mul.sv
// ----------------------------------------------------------------------------
// mcm_mul
// Product stage: sixteen 32x32 signed multipliers, one per (k, row) pair.
// ----------------------------------------------------------------------------
`default_nettype none

module mcm_mul (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire mcm_pkg::stage_tag_t in_tag,
  input  wire mcm_pkg::col_vec_t   in_b,
  input  wire mcm_pkg::mat_t       mat,
  output logic                     in_rdy,
  output mcm_pkg::stage_tag_t      out_tag,
  output mcm_pkg::prod_mat_t       out_prod,
  input  wire logic                out_rdy
);
  import mcm_pkg::*;

  stage_tag_t tag_r;
  prod_mat_t  prod_r;
  prod_mat_t  prod_nxt;

  assign in_rdy = !tag_r.vld || out_rdy;

  always_comb begin
    for (int k = 0; k < N; k++) begin
      for (int r = 0; r < N; r++) begin
        prod_nxt[k][r] = PROD_W'($signed(mat[k][r]) * $signed(in_b[k]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_rdy) begin
      tag_r.col <= in_tag.col;
      prod_r    <= prod_nxt;
    end
    if (!rst_n) begin
      tag_r.vld <= 1'b0;
    end else if (in_rdy) begin
      tag_r.vld <= in_tag.vld;
    end
  end

  assign out_tag  = tag_r;
  assign out_prod = prod_r;

endmodule

`default_nettype wire

// File: design/mcm_reduce.sv
// ----------------------------------------------------------------------------
// mcm_reduce
// Scale the products, sum them in two registered levels and saturate.
// ----------------------------------------------------------------------------
`default_nettype none

module mcm_reduce #(
  parameter int FRAC_BITS = mcm_pkg::FRAC_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire mcm_pkg::stage_tag_t in_tag,
  input  wire mcm_pkg::prod_mat_t  in_prod,
  output logic                     in_rdy,
  output mcm_pkg::stage_tag_t      out_tag,
  output mcm_pkg::col_vec_t        out_sum,
  input  wire logic                out_rdy
);
  import mcm_pkg::*;

  localparam int SH_W   = PROD_W - FRAC_BITS;
  localparam int PAIR_W = SH_W + 1;
  localparam int TOT_W  = SH_W + 2;

  stage_tag_t pair_tag_r;
  logic signed [PAIR_W-1:0] pair_r   [2][N];
  logic signed [PAIR_W-1:0] pair_nxt [2][N];
  logic signed [SH_W-1:0]   sh       [N][N];
  logic                     pair_rdy;

  stage_tag_t out_tag_r;
  col_vec_t   sum_r;
  col_vec_t   sum_nxt;
  logic signed [TOT_W-1:0]  tot      [N];
  logic [TOT_W-ELEM_W:0]    tot_hi   [N];

  assign pair_rdy = !out_tag_r.vld || out_rdy;
  assign in_rdy   = !pair_tag_r.vld || pair_rdy;

  always_comb begin
    for (int k = 0; k < N; k++) begin
      for (int r = 0; r < N; r++) begin
        sh[k][r] = SH_W'($signed(in_prod[k][r]) >>> FRAC_BITS);
      end
    end
    for (int r = 0; r < N; r++) begin
      pair_nxt[0][r] = PAIR_W'(sh[0][r]) + PAIR_W'(sh[1][r]);
      pair_nxt[1][r] = PAIR_W'(sh[2][r]) + PAIR_W'(sh[3][r]);
    end
  end

  always_comb begin
    for (int r = 0; r < N; r++) begin
      tot[r]    = TOT_W'(pair_r[0][r]) + TOT_W'(pair_r[1][r]);
      tot_hi[r] = tot[r][TOT_W-1:ELEM_W-1];
      if ((&tot_hi[r]) || !(|tot_hi[r])) begin
        sum_nxt[r] = tot[r][ELEM_W-1:0];
      end else if (tot[r][TOT_W-1]) begin
        sum_nxt[r] = SAT_MIN;
      end else begin
        sum_nxt[r] = SAT_MAX;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_rdy) begin
      pair_tag_r.col <= in_tag.col;
      pair_r         <= pair_nxt;
    end
    if (pair_rdy) begin
      out_tag_r.col <= pair_tag_r.col;
      sum_r         <= sum_nxt;
    end
    if (!rst_n) begin
      pair_tag_r.vld <= 1'b0;
      out_tag_r.vld  <= 1'b0;
    end else begin
      if (in_rdy) begin
        pair_tag_r.vld <= in_tag.vld;
      end
      if (pair_rdy) begin
        out_tag_r.vld <= pair_tag_r.vld;
      end
    end
  end

  assign out_tag = out_tag_r;
  assign out_sum = sum_r;

endmodule

`default_nettype wire

// File: tb/mat4_column_major_multiply_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mat4_column_major_multiply_unit_test
// Self-checking bench for the 4x4 column-major Q16.16 matrix multiply unit.
// A short table of directed columns comes first: identity, full-scale and
// smallest-step left matrices, with saturation and floor rounding. Random
// load/multiply traffic follows, mostly as whole matrix passes. Every product
// column is checked: directed ones against the table, others against an in-bench
// model of C = A * B. Both sides idle at random, with one long output hold-off.
// ----------------------------------------------------------------------------

module mat4_column_major_multiply_unit_test;
  import mcm_pkg::*;

  localparam int FRAC           = FRAC_BITS_DEF;
  localparam int RANDOM_ITEMS   = 2000;
  localparam int CALM_ITEMS     = 300;
  localparam int LONG_HOLD_AT   = 1200;
  localparam int LONG_HOLD      = 200;
  localparam int DRAIN_CYCLES   = 10;
  localparam int WATCHDOG_LIMIT = 2000;

  localparam logic [ELEM_W-1:0] Q_ONE  = 32'h0001_0000;
  localparam logic [ELEM_W-1:0] Q_MAX  = 32'h7FFF_FFFF;
  localparam logic [ELEM_W-1:0] Q_MIN  = 32'h8000_0000;
  localparam logic [ELEM_W-1:0] Q_LSB  = 32'h0000_0001;
  localparam logic [ELEM_W-1:0] Q_NEG1 = 32'hFFFF_FFFF;

  localparam longint ROW_MAX = 64'sd2147483647;
  localparam longint ROW_MIN = -64'sd2147483648;

  typedef struct packed {
    col_t     col;
    col_vec_t rows;
  } product_col_t;

  typedef struct {
    op_t      op;
    col_t     col;
    bit       typed;
    col_vec_t elems;
    col_vec_t want;
  } stim_row_t;

  logic              clk        = 1'b0;
  logic              rst_n      = 1'b0;
  logic              in_tvalid  = 1'b0;
  logic              in_tready;
  logic [DATA_W-1:0] in_tdata   = '0;
  logic              in_tuser   = 1'b0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [DATA_W-1:0] out_tdata;

  mat_t         left_cols;
  product_col_t pending_products [$];
  stim_row_t    directed_rows [$];
  product_col_t want_col;
  col_vec_t     got_rows;

  int unsigned mismatches     = 0;
  int unsigned columns_seen   = 0;
  int unsigned load_count     = 0;
  int unsigned mul_count      = 0;
  int unsigned gap_odds       = 4;
  int unsigned hold_left      = 0;
  int unsigned rx_cycle       = 0;
  int unsigned quiet_cycles   = 0;
  logic        calm           = 1'b0;

  mat4_column_major_multiply_unit #(
    .FRAC_BITS (FRAC)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic col_vec_t column_of(logic [ELEM_W-1:0] e0, logic [ELEM_W-1:0] e1,
                                         logic [ELEM_W-1:0] e2, logic [ELEM_W-1:0] e3);
    return {e3, e2, e1, e0};
  endfunction

  // Row r: sum over k of floor(A[k][r] * b[k] / 2^FRAC), saturated to 32 bits.
  function automatic col_vec_t product_column(col_vec_t b);
    col_vec_t c;
    longint   acc;
    longint   term;
    for (int r = 0; r < N; r++) begin
      acc = 0;
      for (int k = 0; k < N; k++) begin
        term = longint'($signed(left_cols[k][r])) * longint'($signed(b[k]));
        acc += term >>> FRAC;
      end
      if (acc > ROW_MAX) begin
        c[r] = SAT_MAX;
      end else if (acc < ROW_MIN) begin
        c[r] = SAT_MIN;
      end else begin
        c[r] = acc[ELEM_W-1:0];
      end
    end
    return c;
  endfunction

  function automatic logic [ELEM_W-1:0] rand_elem();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return $urandom_range(0, 32'h001F_FFFF) - 32'h0010_0000;
      2: return $urandom_range(0, 32'h01FF_FFFF) - 32'h0100_0000;
      3: begin
        case ($urandom_range(0, 4))
          0:       return Q_MAX;
          1:       return Q_MIN;
          2:       return '0;
          3:       return Q_NEG1;
          default: return Q_ONE;
        endcase
      end
      default: return $urandom_range(0, 15) - 8;
    endcase
  endfunction

  function automatic col_vec_t rand_column();
    return column_of(rand_elem(), rand_elem(), rand_elem(), rand_elem());
  endfunction

  task automatic add_row(input op_t op, input col_t col, input bit typed,
                         input col_vec_t elems, input col_vec_t want);
    directed_rows.push_back('{op: op, col: col, typed: typed, elems: elems, want: want});
  endtask

  task automatic report_mismatch(input string field, input logic [ELEM_W-1:0] got,
                                 input logic [ELEM_W-1:0] want);
    $display("%0t: mismatch on %s: got %h, expected %h", $realtime, field, got, want);
    mismatches++;
  endtask

  task automatic offer_item(input op_t op, input col_t col, input col_vec_t elems,
                            input bit typed, input col_vec_t want);
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {{(DATA_W - DATA_BITS){1'b0}}, elems, col};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (op == OP_LOAD) begin
      left_cols[col] = elems;
      load_count++;
    end else begin
      pending_products.push_back('{col: col, rows: typed ? want : product_column(elems)});
      mul_count++;
    end
  endtask

  task automatic pause_sender();
    if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  initial begin : stimulus
    int unsigned random_items;
    col_vec_t    zero_col;
    zero_col     = '0;
    random_items = 0;

    // identity A passes the column through
    add_row(OP_LOAD, 2'd0, 1'b0, column_of(Q_ONE, 0, 0, 0), zero_col);
    add_row(OP_LOAD, 2'd1, 1'b0, column_of(0, Q_ONE, 0, 0), zero_col);
    add_row(OP_LOAD, 2'd2, 1'b0, column_of(0, 0, Q_ONE, 0), zero_col);
    add_row(OP_LOAD, 2'd3, 1'b0, column_of(0, 0, 0, Q_ONE), zero_col);
    add_row(OP_MUL, 2'd0, 1'b1, column_of(Q_MAX, Q_MIN, 0, Q_LSB),
            column_of(Q_MAX, Q_MIN, 0, Q_LSB));
    add_row(OP_MUL, 2'd3, 1'b1, column_of(Q_NEG1, 32'h1234_5678, 32'hDEAD_BEEF, Q_ONE),
            column_of(Q_NEG1, 32'h1234_5678, 32'hDEAD_BEEF, Q_ONE));
    // full-scale positive A saturates both ways
    for (int c = 0; c < N; c++) begin
      add_row(OP_LOAD, col_t'(c), 1'b0, column_of(Q_MAX, Q_MAX, Q_MAX, Q_MAX), zero_col);
    end
    add_row(OP_MUL, 2'd1, 1'b1, column_of(Q_MAX, Q_MAX, Q_MAX, Q_MAX),
            column_of(SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX));
    add_row(OP_MUL, 2'd2, 1'b1, column_of(Q_MIN, Q_MIN, Q_MIN, Q_MIN),
            column_of(SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN));
    add_row(OP_MUL, 2'd0, 1'b1, zero_col, zero_col);
    // full-scale negative A
    for (int c = 0; c < N; c++) begin
      add_row(OP_LOAD, col_t'(c), 1'b0, column_of(Q_MIN, Q_MIN, Q_MIN, Q_MIN), zero_col);
    end
    add_row(OP_MUL, 2'd1, 1'b1, column_of(Q_MIN, Q_MIN, Q_MIN, Q_MIN),
            column_of(SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX));
    add_row(OP_MUL, 2'd2, 1'b1, column_of(Q_MAX, Q_MAX, Q_MAX, Q_MAX),
            column_of(SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN));
    // smallest step: products round toward minus infinity
    for (int c = 0; c < N; c++) begin
      add_row(OP_LOAD, col_t'(c), 1'b0, column_of(Q_LSB, Q_LSB, Q_LSB, Q_LSB), zero_col);
    end
    add_row(OP_MUL, 2'd3, 1'b1, column_of(Q_NEG1, Q_NEG1, Q_NEG1, Q_NEG1),
            column_of(32'hFFFF_FFFC, 32'hFFFF_FFFC, 32'hFFFF_FFFC, 32'hFFFF_FFFC));
    add_row(OP_MUL, 2'd0, 1'b1, column_of(Q_LSB, Q_LSB, Q_LSB, Q_LSB), zero_col);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      offer_item(directed_rows[i].op, directed_rows[i].col, directed_rows[i].elems,
                 directed_rows[i].typed, directed_rows[i].want);
      pause_sender();
    end

    while (random_items < RANDOM_ITEMS) begin
      if (random_items + CALM_ITEMS >= RANDOM_ITEMS) begin
        gap_odds = 0;
        calm    <= 1'b1;
      end else if ($urandom_range(0, 39) == 0) begin
        case ($urandom_range(0, 2))
          0:       gap_odds = 0;
          1:       gap_odds = 2;
          default: gap_odds = 6;
        endcase
      end
      if ($urandom_range(0, 9) < 6) begin
        // whole pass: load all of A, then multiply four columns of B
        for (int c = 0; c < N; c++) begin
          offer_item(OP_LOAD, col_t'(c), rand_column(), 1'b0, '0);
          pause_sender();
        end
        for (int c = 0; c < N; c++) begin
          offer_item(OP_MUL, col_t'($urandom_range(0, 3)), rand_column(), 1'b0, '0);
          pause_sender();
        end
        random_items += 2 * N;
      end else begin
        offer_item($urandom_range(0, 1) ? OP_MUL : OP_LOAD, col_t'($urandom_range(0, 3)),
                   rand_column(), 1'b0, '0);
        pause_sender();
        random_items++;
      end
    end
    in_tvalid <= 1'b0;

    while (pending_products.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d column loads and %0d multiplies; %0d product columns checked.",
             load_count, mul_count, columns_seen);
    $display("Output held off %0d cycles once; %0d mismatches.", LONG_HOLD, mismatches);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Drive out_tready: random stall bursts, one long hold-off, none once calm.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      rx_cycle <= rx_cycle + 1;
      if (rx_cycle == LONG_HOLD_AT) begin
        hold_left  <= LONG_HOLD - 1;
        out_tready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left  <= hold_left - 1;
        out_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        hold_left  <= $urandom_range(0, 4);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      columns_seen++;
      got_rows = out_tdata[DATA_BITS-1:COL_W];
      if (pending_products.size() == 0) begin
        report_mismatch("unexpected product column", ELEM_W'(1), '0);
      end else begin
        want_col = pending_products.pop_front();
        if (out_tdata[COL_W-1:0] !== want_col.col) begin
          report_mismatch("out_column", ELEM_W'(out_tdata[COL_W-1:0]), ELEM_W'(want_col.col));
        end
        for (int r = 0; r < N; r++) begin
          if (got_rows[r] !== want_col.rows[r]) begin
            report_mismatch($sformatf("prod%0d", r), got_rows[r], want_col.rows[r]);
          end
        end
      end
    end
  end

  // End the run when no transfer happens on either side for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("Timeout: no transfer for %0d cycles, %0d columns pending.",
               WATCHDOG_LIMIT, pending_products.size());
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

// File: sim.f
design/mcm_pkg.sv
design/mcm_col_store.sv
design/mcm_mul.sv
design/mcm_reduce.sv
design/mat4_column_major_multiply_unit.sv
tb/mat4_column_major_multiply_unit_test.sv
